// File: src/tsc_pkg.sv
// Shared constants, codes and types of the tile slot cache.
package tsc_pkg;

    localparam int TILE_IDS_DEF = 4096;
    localparam int BATCH_MAX    = 16;

    localparam int OP_W    = 2;
    localparam int ID_W    = 12;
    localparam int SLOT_W  = 12;
    localparam int CNT_W   = 13;
    localparam int BLEN_W  = 5;
    localparam int BLIM_W  = 7;
    localparam int WIDE_W  = 17;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 13;
    localparam int SLOT_SPACE = 4096;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [CFG_A_W-1:0] CFG_TILE_ID_LIMIT = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_SLOT_CAPACITY = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_BATCH_LIMIT   = 2'd2;

    localparam logic [CNT_W-1:0]  RST_TILE_ID_LIMIT = 13'd2870;
    localparam logic [CNT_W-1:0]  RST_SLOT_CAPACITY = 13'd1190;
    localparam logic [BLEN_W-1:0] RST_BATCH_LIMIT   = 5'd16;

    typedef struct packed {
        logic accept;
        logic look;
        logic eval;
    } t_cmd;

endpackage

// File: src/tsc_ctrl.sv
// Controller state machine sequencing the two table reads and the update.
module tsc_ctrl
    import tsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_READ_MAP = 2'd1;
    localparam logic [1:0] S_READ_REV = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ_MAP;
                end
            end
            S_READ_MAP: begin
                n_state = S_READ_REV;
            end
            S_READ_REV: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.look   = (r_state == S_READ_MAP);
    assign o_cmd.eval   = (r_state == S_READ_REV);

endmodule

// File: src/tsc_dp.sv
// Datapath: id map, reverse slot table, bump counter, batch state and result registers.
module tsc_dp
    import tsc_pkg::*;
#(
    parameter int TILE_IDS = TILE_IDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [OP_W-1:0]    i_op,
    input  logic [ID_W-1:0]    i_tile_id,
    input  logic [CNT_W-1:0]   i_tile_id_limit,
    input  logic [CNT_W-1:0]   i_slot_capacity,
    input  logic [BLEN_W-1:0]  i_batch_limit,
    output logic               o_done,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_hit,
    output logic               o_overflow,
    output logic               o_overflow_sticky,
    output logic               o_fetch_tile,
    output logic               o_flush_valid,
    output logic [SLOT_W-1:0]  o_flush_start,
    output logic [BLEN_W-1:0]  o_flush_count
);

    localparam int IDW = $clog2(TILE_IDS);

    logic [SLOT_W-1:0] r_map_mem [TILE_IDS];
    logic [IDW-1:0]    r_rev_mem [SLOT_SPACE];

    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [SLOT_W-1:0] r_map_q;
    logic [IDW-1:0]    r_rev_q;

    logic [CNT_W-1:0]  r_next_free, n_next_free;
    logic              r_ovf, n_ovf;
    logic [SLOT_W-1:0] r_bfirst, n_bfirst;
    logic [BLEN_W-1:0] r_blen, n_blen;

    logic              r_done;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_hit, n_hit;
    logic              r_ovf_now, n_ovf_now;
    logic              r_fetch, n_fetch;
    logic              r_fv, n_fv;
    logic [SLOT_W-1:0] r_fstart, n_fstart;
    logic [BLEN_W-1:0] r_fcount, n_fcount;
    logic              n_alloc;

    logic [WIDE_W-1:0] in_wide;
    logic [WIDE_W-1:0] id_wide;
    logic [IDW-1:0]    in_idx;
    logic [IDW-1:0]    id_idx;
    logic [CNT_W-1:0]  cap;
    logic [BLIM_W-1:0] eff_lim;
    logic              range_bad;
    logic              map_hit;
    logic [BLEN_W-1:0] blen_mid;

    assign in_wide = {{(WIDE_W-ID_W){1'b0}}, i_tile_id};
    assign id_wide = {{(WIDE_W-ID_W){1'b0}}, r_id};
    assign in_idx  = in_wide[IDW-1:0];
    assign id_idx  = id_wide[IDW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_id    <= i_tile_id;
            r_map_q <= r_map_mem[in_idx];
        end
        if (i_cmd.look) begin
            r_rev_q <= r_rev_mem[r_map_q];
        end
        if (i_cmd.eval && n_alloc) begin
            r_map_mem[id_idx]            <= r_next_free[SLOT_W-1:0];
            r_rev_mem[r_next_free[SLOT_W-1:0]] <= id_idx;
        end
    end

    always_comb begin
        cap = (i_slot_capacity > CNT_W'(SLOT_SPACE)) ? CNT_W'(SLOT_SPACE) : i_slot_capacity;
        if (i_batch_limit == '0) begin
            eff_lim = BLIM_W'(1);
        end else if (BLIM_W'(i_batch_limit) > BLIM_W'(BATCH_MAX)) begin
            eff_lim = BLIM_W'(BATCH_MAX);
        end else begin
            eff_lim = BLIM_W'(i_batch_limit);
        end
        range_bad = ({1'b0, r_id} >= i_tile_id_limit) || (id_wide >= WIDE_W'(TILE_IDS));
        map_hit   = ({1'b0, r_map_q} < r_next_free) && (r_rev_q == id_idx);

        n_next_free = r_next_free;
        n_ovf       = r_ovf;
        n_bfirst    = r_bfirst;
        n_blen      = r_blen;
        n_slot      = '0;
        n_hit       = 1'b0;
        n_ovf_now   = 1'b0;
        n_fetch     = 1'b0;
        n_fv        = 1'b0;
        n_fstart    = '0;
        n_fcount    = '0;
        n_alloc     = 1'b0;
        blen_mid    = r_blen;

        case (r_op)
            OP_ACQUIRE: begin
                if (range_bad) begin
                    n_ovf     = 1'b1;
                    n_ovf_now = 1'b1;
                end else if (map_hit) begin
                    n_slot = r_map_q;
                    n_hit  = 1'b1;
                end else if (r_next_free >= cap) begin
                    n_ovf     = 1'b1;
                    n_ovf_now = 1'b1;
                end else begin
                    n_alloc     = 1'b1;
                    n_next_free = r_next_free + CNT_W'(1);
                    if ((BLIM_W'(r_blen) >= eff_lim) ||
                        ((r_blen != '0) &&
                         (({1'b0, r_bfirst} + CNT_W'(r_blen)) != r_next_free))) begin
                        n_fv     = 1'b1;
                        n_fstart = r_bfirst;
                        n_fcount = r_blen;
                        blen_mid = '0;
                    end
                    if (blen_mid == '0) begin
                        n_bfirst = r_next_free[SLOT_W-1:0];
                    end
                    n_blen  = blen_mid + BLEN_W'(1);
                    n_slot  = r_next_free[SLOT_W-1:0];
                    n_fetch = 1'b1;
                end
            end
            OP_FLUSH: begin
                if (r_blen != '0) begin
                    n_fv     = 1'b1;
                    n_fstart = r_bfirst;
                    n_fcount = r_blen;
                    n_blen   = '0;
                end
            end
            OP_CLEAR: begin
                n_next_free = '0;
                n_ovf       = 1'b0;
                n_bfirst    = '0;
                n_blen      = '0;
            end
            default: begin
                n_ovf = r_ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
            r_ovf       <= 1'b0;
            r_bfirst    <= '0;
            r_blen      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.eval;
            if (i_cmd.eval) begin
                r_next_free <= n_next_free;
                r_ovf       <= n_ovf;
                r_bfirst    <= n_bfirst;
                r_blen      <= n_blen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_slot    <= n_slot;
            r_hit     <= n_hit;
            r_ovf_now <= n_ovf_now;
            r_fetch   <= n_fetch;
            r_fv      <= n_fv;
            r_fstart  <= n_fstart;
            r_fcount  <= n_fcount;
        end
    end

    assign o_done            = r_done;
    assign o_slot            = r_slot;
    assign o_hit             = r_hit;
    assign o_overflow        = r_ovf_now;
    assign o_overflow_sticky = r_ovf;
    assign o_fetch_tile      = r_fetch;
    assign o_flush_valid     = r_fv;
    assign o_flush_start     = r_fstart;
    assign o_flush_count     = r_fcount;

endmodule

// File: src/tile_slot_cache_with_upload_batching.sv
// Top level of the tile slot cache: configuration registers, controller and datapath.
// Each accepted item passes the id map read, the reverse slot table read and the update;
// its result is strobed on o_done for one cycle, in which a new item may be accepted; none before it.
// The rate is set by the id map read followed by the dependent reverse slot table read.
// Reset (synchronous, active low) restores the registers, empties counter, flag and batch;
// the map needs no clearing pass: an entry counts only if its slot lies below the counter
// and the reverse table names the same id. The receiver cannot stall results.
module tile_slot_cache_with_upload_batching
    import tsc_pkg::*;
#(
    parameter int TILE_IDS = TILE_IDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [OP_W-1:0]    i_op,
    input  logic [ID_W-1:0]    i_tile_id,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_D_W-1:0] i_cfg_wdata,
    output logic               o_done,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_hit,
    output logic               o_overflow,
    output logic               o_overflow_sticky,
    output logic               o_fetch_tile,
    output logic               o_flush_valid,
    output logic [SLOT_W-1:0]  o_flush_start,
    output logic [BLEN_W-1:0]  o_flush_count
);

    logic [CNT_W-1:0]  r_tile_id_limit;
    logic [CNT_W-1:0]  r_slot_capacity;
    logic [BLEN_W-1:0] r_batch_limit;
    t_cmd              cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_id_limit <= RST_TILE_ID_LIMIT;
            r_slot_capacity <= RST_SLOT_CAPACITY;
            r_batch_limit   <= RST_BATCH_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TILE_ID_LIMIT: r_tile_id_limit <= i_cfg_wdata;
                CFG_SLOT_CAPACITY: r_slot_capacity <= i_cfg_wdata;
                CFG_BATCH_LIMIT:   r_batch_limit   <= i_cfg_wdata[BLEN_W-1:0];
                default: begin
                    r_batch_limit <= r_batch_limit;
                end
            endcase
        end
    end

    tsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    tsc_dp #(
        .TILE_IDS (TILE_IDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_op              (i_op),
        .i_tile_id         (i_tile_id),
        .i_tile_id_limit   (r_tile_id_limit),
        .i_slot_capacity   (r_slot_capacity),
        .i_batch_limit     (r_batch_limit),
        .o_done            (o_done),
        .o_slot            (o_slot),
        .o_hit             (o_hit),
        .o_overflow        (o_overflow),
        .o_overflow_sticky (o_overflow_sticky),
        .o_fetch_tile      (o_fetch_tile),
        .o_flush_valid     (o_flush_valid),
        .o_flush_start     (o_flush_start),
        .o_flush_count     (o_flush_count)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not occupy the block");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobed while still busy");
    a_hit_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_fetch_tile) && !(o_hit && o_overflow))
        else $error("conflicting hit, fetch and overflow");
    a_ovf_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow) |-> (o_slot == '0) && o_overflow_sticky)
        else $error("overflow result carries a slot or no sticky flag");
    a_flush_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_flush_valid) |-> (o_flush_count != '0))
        else $error("empty batch emitted");
`endif

endmodule
